@@ rtl/pts_pkg.sv @@
`default_nettype none

package pts_pkg;

  // Field and register widths.
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned AMP_BITS      = 16;
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned MAG_BITS      = AMP_BITS - 1;
  localparam int unsigned SPAN_BITS     = TIME_BITS + COUNT_BITS;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = TIME_BITS;

  // Number of remainder cells: one quotient bit per cell.
  localparam int unsigned N_CELLS = TIME_BITS;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_START_TIME    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_FIRST  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_FIRST   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_SECOND = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_SECOND  = 3'd6;

  // Train codes on the output.
  localparam logic [1:0] TRAIN_NONE   = 2'd0;
  localparam logic [1:0] TRAIN_FIRST  = 2'd1;
  localparam logic [1:0] TRAIN_SECOND = 2'd2;

  // Configuration register contents.
  typedef struct packed {
    logic [TIME_BITS-1:0]  start_time;
    logic [TIME_BITS-1:0]  period_first;
    logic [TIME_BITS-1:0]  pulse_width;
    logic [MAG_BITS-1:0]   amplitude;
    logic [COUNT_BITS-1:0] count_first;
    logic [TIME_BITS-1:0]  period_second;
    logic [COUNT_BITS-1:0] count_second;
  } pts_cfg_t;

  // Data handed from one remainder cell to the next.
  typedef struct packed {
    logic [TIME_BITS-1:0] dvd1;
    logic [TIME_BITS-1:0] dvd2;
    logic [TIME_BITS-1:0] rem1;
    logic [TIME_BITS-1:0] rem2;
    logic                 win1;
    logic                 win2;
  } pts_cell_t;

endpackage

`default_nettype wire

@@ rtl/pts_cfg.sv @@
`default_nettype none

module pts_cfg import pts_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output pts_cfg_t                      cfg_o
);

  pts_cfg_t cfg_d, cfg_q;

  // Decode the write; unknown indexes are ignored and upper bits dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_TIME:    cfg_d.start_time    = cfg_data_i[TIME_BITS-1:0];
        REG_PERIOD_FIRST:  cfg_d.period_first  = cfg_data_i[TIME_BITS-1:0];
        REG_PULSE_WIDTH:   cfg_d.pulse_width   = cfg_data_i[TIME_BITS-1:0];
        REG_AMPLITUDE:     cfg_d.amplitude     = cfg_data_i[MAG_BITS-1:0];
        REG_COUNT_FIRST:   cfg_d.count_first   = cfg_data_i[COUNT_BITS-1:0];
        REG_PERIOD_SECOND: cfg_d.period_second = cfg_data_i[TIME_BITS-1:0];
        REG_COUNT_SECOND:  cfg_d.count_second  = cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_time    <= '0;
      cfg_q.period_first  <= '0;
      cfg_q.pulse_width   <= '0;
      cfg_q.amplitude     <= '0;
      cfg_q.count_first   <= COUNT_BITS'(1);
      cfg_q.period_second <= '0;
      cfg_q.count_second  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/pts_cell.sv @@
`default_nettype none

module pts_cell import pts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 valid_i,
  input  wire pts_cell_t            data_i,
  input  wire logic [TIME_BITS-1:0] period_first_i,
  input  wire logic [TIME_BITS-1:0] period_second_i,
  output logic                      valid_o,
  output pts_cell_t                 data_o
);

  logic [TIME_BITS:0] trial1, trial2;
  logic [TIME_BITS:0] diff1, diff2;
  pts_cell_t          data_d, data_q;
  logic               valid_q;

  // One restoring step for each train: bring in the next dividend bit and
  // subtract the period when the partial remainder reaches it.
  always_comb begin
    trial1 = {data_i.rem1, data_i.dvd1[TIME_BITS-1]};
    trial2 = {data_i.rem2, data_i.dvd2[TIME_BITS-1]};
    diff1  = trial1 - {1'b0, period_first_i};
    diff2  = trial2 - {1'b0, period_second_i};
    data_d = data_i;
    data_d.dvd1 = data_i.dvd1 << 1;
    data_d.dvd2 = data_i.dvd2 << 1;
    data_d.rem1 = (trial1 >= {1'b0, period_first_i}) ? diff1[TIME_BITS-1:0]
                                                     : trial1[TIME_BITS-1:0];
    data_d.rem2 = (trial2 >= {1'b0, period_second_i}) ? diff2[TIME_BITS-1:0]
                                                      : trial2[TIME_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/s1_s2_pulse_train_stimulus.sv @@
// Two-train pacing stimulus. Each request carries one time value in ticks and
// yields one result: the negated amplitude while inside a pulse of the S1
// train (start_time onward, count_first periods) or of the S2 train (right
// after S1, count_second periods), else zero, with an active flag and a train
// code; S1 wins when both match. A new request is taken every cycle unless a
// held result backs up the stages. The offset modulo each period is worked out
// by a chain of TIME_BITS
// remainder cells, one quotient bit per cell, ahead of which sit one stage for
// the offset and the train span products and one for the window tests, and
// after which sits the output register. Bubbles in the chain close up while a
// result waits, so requests keep flowing until the chain is full. Configure
// only while no request is in flight.

`default_nettype none

module s1_s2_pulse_train_stimulus import pts_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [TIME_BITS-1:0]     time_now_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [AMP_BITS-1:0]    stimulus_o,
  output logic                          pulse_active_o,
  output logic [1:0]                    train_o
);

  localparam int unsigned N_STG = N_CELLS + 3;
  localparam int unsigned OUT_STG = N_STG - 1;

  pts_cfg_t              cfg;
  logic [N_STG-1:0]      vld;
  logic [N_STG-1:0]      adv;
  pts_cell_t             cd [N_CELLS+1];

  logic                  ge0_q;
  logic [TIME_BITS-1:0]  tp0_q;
  logic [SPAN_BITS-1:0]  span1_q, span2_q;
  logic                  v0_q, v1_q, vo_q;
  pts_cell_t             s1_d, s1_q;
  logic                  ge_span;
  logic [SPAN_BITS-1:0]  tp_ext, tp2_ext;

  logic                  hit1, hit2;
  logic [1:0]            train_d, train_q;
  logic signed [AMP_BITS-1:0] stim_d, stim_q;

  pts_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // A stage moves when it is empty or the stage after it moves.
  assign vld[0]       = v0_q;
  assign vld[1]       = v1_q;
  assign vld[OUT_STG] = vo_q;
  assign adv[OUT_STG] = ~vo_q | out_ready_i;

  for (genvar s = 0; s < OUT_STG; s++) begin : g_adv
    assign adv[s] = ~vld[s] | adv[s+1];
  end

  assign in_ready_o = adv[0];

  // Offset stage: time past start and the span of each train.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ge0_q   <= (time_now_i >= cfg.start_time);
      tp0_q   <= time_now_i - cfg.start_time;
      span1_q <= SPAN_BITS'(cfg.period_first) * SPAN_BITS'(cfg.count_first);
      span2_q <= SPAN_BITS'(cfg.period_second) * SPAN_BITS'(cfg.count_second);
    end
  end

  // Window stage: inclusive window tests and the offset into S2. A zero span
  // means a zero period or count, which disables that train.
  always_comb begin
    tp_ext  = SPAN_BITS'(tp0_q);
    ge_span = (tp_ext >= span1_q);
    tp2_ext = tp_ext - span1_q;
    s1_d.dvd1 = tp0_q;
    s1_d.dvd2 = tp2_ext[TIME_BITS-1:0];
    s1_d.rem1 = '0;
    s1_d.rem2 = '0;
    s1_d.win1 = ge0_q && (span1_q != '0) && (tp_ext <= span1_q);
    s1_d.win2 = ge0_q && ge_span && (span2_q != '0) && (tp2_ext <= span2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv[1]) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_q <= s1_d;
    end
  end

  assign cd[0] = s1_q;

  // Remainder chain: each cell resolves one more dividend bit.
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    pts_cell u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .adv_i           (adv[k+2]),
      .valid_i         (vld[k+1]),
      .data_i          (cd[k]),
      .period_first_i  (cfg.period_first),
      .period_second_i (cfg.period_second),
      .valid_o         (vld[k+2]),
      .data_o          (cd[k+1])
    );
  end

  // Pulse test on the final remainders; S1 takes priority.
  always_comb begin
    hit1 = cd[N_CELLS].win1 && (cd[N_CELLS].rem1 <= cfg.pulse_width);
    hit2 = cd[N_CELLS].win2 && (cd[N_CELLS].rem2 <= cfg.pulse_width);
    if (hit1) begin
      train_d = TRAIN_FIRST;
    end else if (hit2) begin
      train_d = TRAIN_SECOND;
    end else begin
      train_d = TRAIN_NONE;
    end
    stim_d = (hit1 || hit2) ? AMP_BITS'(-$signed({1'b0, cfg.amplitude})) : '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv[OUT_STG]) begin
      vo_q <= vld[OUT_STG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[OUT_STG]) begin
      train_q <= train_d;
      stim_q  <= stim_d;
    end
  end

  assign out_valid_o    = vo_q;
  assign stimulus_o     = stim_q;
  assign train_o        = train_q;
  assign pulse_active_o = (train_q != TRAIN_NONE);

  // An accepted request lands in the offset stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v0_q)
    else $error("accepted request did not enter the offset stage");

  // A held result blocks the output stage.
  a_hold_blocks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !out_ready_i) |-> !adv[OUT_STG])
    else $error("output stage advanced while its result was held");

  // A nonzero stimulus only comes with a pulse of one of the trains.
  a_stim_in_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (stimulus_o != '0)) |->
      (train_o == TRAIN_FIRST || train_o == TRAIN_SECOND))
    else $error("stimulus driven outside a pulse");

endmodule

`default_nettype wire

@@ tb/pts_checker.sv @@
`timescale 1ns / 1ps

module pts_checker import pts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [TIME_BITS-1:0]     time_now_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [AMP_BITS-1:0] stimulus_i,
  input  logic                     pulse_active_i,
  input  logic [1:0]               train_i,
  output int                       errors_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [AMP_BITS-1:0] stimulus;
    logic                       active;
    logic [1:0]                 train;
  } stim_res_t;

  // Shadow copy of the register file and the results still owed by the block.
  pts_cfg_t  cfg;
  stim_res_t expected_stim_q [$];

  // True when an offset into a train lands on the inclusive part of a pulse.
  function automatic logic in_pulse(input logic [63:0] offs,
                                    input logic [TIME_BITS-1:0] period,
                                    input logic [COUNT_BITS-1:0] count);
    logic [63:0] span;
    span = 64'(period) * 64'(count);
    if (period == '0 || count == '0) return 1'b0;
    if (offs > span) return 1'b0;
    return (offs % 64'(period)) <= 64'(cfg.pulse_width);
  endfunction

  // Stimulus output for one time query; the first train takes priority.
  function automatic stim_res_t predict_stimulus(input logic [TIME_BITS-1:0] t);
    logic [63:0] offs;
    logic [63:0] span1;
    stim_res_t   r;
    r = '0;
    r.train = TRAIN_NONE;
    if (t >= cfg.start_time) begin
      offs  = 64'(t - cfg.start_time);
      span1 = 64'(cfg.period_first) * 64'(cfg.count_first);
      if (in_pulse(offs, cfg.period_first, cfg.count_first)) begin
        r.train = TRAIN_FIRST;
      end else if (offs >= span1 &&
                   in_pulse(offs - span1, cfg.period_second, cfg.count_second)) begin
        r.train = TRAIN_SECOND;
      end
    end
    if (r.train != TRAIN_NONE) begin
      r.active   = 1'b1;
      r.stimulus = '0 - {1'b0, cfg.amplitude};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors_o++;
  endtask

  // Everything is sampled at the falling edge, where inputs and outputs are
  // stable; a handshake seen here completes at the following rising edge.
  always @(negedge clk_i) begin : watch
    stim_res_t want;
    if (!rst_ni) begin
      cfg = '0;
      cfg.count_first = COUNT_BITS'(1);
      expected_stim_q.delete();
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_TIME:    cfg.start_time    = cfg_data_i;
          REG_PERIOD_FIRST:  cfg.period_first  = cfg_data_i;
          REG_PULSE_WIDTH:   cfg.pulse_width   = cfg_data_i;
          REG_AMPLITUDE:     cfg.amplitude     = cfg_data_i[MAG_BITS-1:0];
          REG_COUNT_FIRST:   cfg.count_first   = cfg_data_i[COUNT_BITS-1:0];
          REG_PERIOD_SECOND: cfg.period_second = cfg_data_i;
          REG_COUNT_SECOND:  cfg.count_second  = cfg_data_i[COUNT_BITS-1:0];
          default: ;
        endcase
      end

      // Compare each returned result against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (expected_stim_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending (stimulus %0d)",
                                    stimulus_i));
        end else begin
          want = expected_stim_q.pop_front();
          if (stimulus_i !== want.stimulus)
            report_mismatch($sformatf("stimulus expected %0d, got %0d",
                                      want.stimulus, stimulus_i));
          if (pulse_active_i !== want.active)
            report_mismatch($sformatf("pulse_active expected %0d, got %0d",
                                      want.active, pulse_active_i));
          if (train_i !== want.train)
            report_mismatch($sformatf("train expected %0d, got %0d",
                                      want.train, train_i));
        end
      end

      // Predict the result of each accepted request.
      if (in_valid_i && in_ready_i)
        expected_stim_q.push_back(predict_stimulus(time_now_i));
    end
    pending_o = expected_stim_q.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import pts_pkg::*;

  localparam int unsigned N_PHASES     = 16;
  localparam int unsigned PHASE_ITEMS  = 53;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [TIME_BITS-1:0]     time_now;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [AMP_BITS-1:0] stimulus;
  logic                     pulse_active;
  logic [1:0]               train;

  int errors;
  int pending;
  int quiet;
  bit idle_en;

  s1_s2_pulse_train_stimulus dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .time_now_i     (time_now),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .stimulus_o     (stimulus),
    .pulse_active_o (pulse_active),
    .train_o        (train)
  );

  pts_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .time_now_i     (time_now),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .stimulus_i     (stimulus),
    .pulse_active_i (pulse_active),
    .train_i        (train),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Stop the run if no request or result moves for too long.
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts while idling is enabled.
  initial begin : receiver
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one time query and return right after the edge that takes it.
  task automatic send_time(input logic [TIME_BITS-1:0] t);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    time_now <= t;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Hold off new requests until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Register write; the caller lowers the enable after the last one.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Pick a query time, often close to pulse edges and train boundaries.
  function automatic logic [TIME_BITS-1:0] pick_tick(input logic [TIME_BITS-1:0] st,
                                                     input logic [TIME_BITS-1:0] pf,
                                                     input logic [COUNT_BITS-1:0] cf,
                                                     input logic [TIME_BITS-1:0] ps,
                                                     input logic [COUNT_BITS-1:0] cs);
    logic [63:0] span1;
    logic [63:0] span2;
    logic [63:0] offs;
    span1 = 64'(pf) * 64'(cf);
    span2 = 64'(ps) * 64'(cs);
    case ($urandom_range(0, 9))
      0: return TIME_BITS'($urandom());
      1: return st - TIME_BITS'($urandom_range(1, 3));
      2: offs = span1 + 64'($urandom_range(0, 2)) - 64'd1;
      3: offs = 64'(pf) * 64'($urandom_range(0, cf)) + 64'($urandom_range(0, 3));
      4: offs = span1 + 64'(ps) * 64'($urandom_range(0, cs)) + 64'($urandom_range(0, 3));
      default: begin
        if (span1 + span2 < 64'd2000) offs = 64'($urandom_range(0, 32'(span1 + span2 + 4)));
        else offs = 64'($urandom());
      end
    endcase
    return st + offs[TIME_BITS-1:0];
  endfunction

  initial begin : stim
    int unsigned ph;
    int unsigned k;
    int unsigned style;
    logic [31:0] st_w, pf_w, pw_w, amp_w, cf_w, ps_w, cs_w;

    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_START_TIME;
    cfg_data = '0;
    in_valid = 1'b0;
    time_now = '0;
    idle_en  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset both trains are off.
    send_time('0);
    send_time('1);
    drain();

    // Two short trains back to back; the unused index must not disturb them.
    write_reg(REG_START_TIME, 32'd100);
    write_reg(REG_PERIOD_FIRST, 32'd10);
    write_reg(REG_COUNT_FIRST, 32'd3);
    write_reg(REG_PULSE_WIDTH, 32'd2);
    write_reg(REG_AMPLITUDE, 32'd32767);
    write_reg(REG_PERIOD_SECOND, 32'd7);
    write_reg(REG_COUNT_SECOND, 32'd2);
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_time(32'd0);
    send_time(32'd99);   // just before start
    send_time(32'd100);
    send_time(32'd102);  // last tick of the width
    send_time(32'd103);
    send_time(32'd129);
    send_time(32'd130);  // both trains match here, the first wins
    send_time(32'd131);
    send_time(32'd132);
    send_time(32'd133);
    send_time(32'd137);
    send_time(32'd144);  // closing edge of the second train
    send_time(32'd145);
    drain();

    // First train off by period, zero amplitude, upper data bits masked.
    write_reg(REG_PERIOD_FIRST, '0);
    write_reg(REG_AMPLITUDE, 32'hFFFF_0000);
    write_reg(REG_COUNT_FIRST, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD_SECOND, 32'd5);
    write_reg(REG_COUNT_SECOND, 32'h1234_0003);
    cfg_we <= 1'b0;
    send_time(32'd99);
    send_time(32'd100);
    send_time(32'd102);
    send_time(32'd103);
    send_time(32'd115);
    send_time(32'd116);
    drain();

    // All registers at their maximum.
    write_reg(REG_START_TIME, '1);
    write_reg(REG_PERIOD_FIRST, '1);
    write_reg(REG_PULSE_WIDTH, '1);
    write_reg(REG_AMPLITUDE, '1);
    write_reg(REG_COUNT_FIRST, '1);
    write_reg(REG_PERIOD_SECOND, '1);
    write_reg(REG_COUNT_SECOND, '1);
    cfg_we <= 1'b0;
    send_time(32'hFFFF_FFFE);
    send_time(32'hFFFF_FFFF);
    drain();

    // First train off by count, so the second starts right at start time.
    write_reg(REG_START_TIME, '0);
    write_reg(REG_PERIOD_FIRST, 32'd8);
    write_reg(REG_COUNT_FIRST, '0);
    write_reg(REG_PULSE_WIDTH, 32'd1);
    write_reg(REG_PERIOD_SECOND, 32'd4);
    write_reg(REG_COUNT_SECOND, 32'd3);
    cfg_we <= 1'b0;
    send_time(32'd0);
    send_time(32'd12);
    send_time(32'd13);
    drain();

    // Random phases, each with its own register setting; quiet at the end.
    for (ph = 0; ph < N_PHASES; ph++) begin
      idle_en = (ph < N_PHASES - 3) && ($urandom_range(0, 3) != 0);
      style   = $urandom_range(0, 3);
      if (style < 2) begin
        st_w = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 300);
        pf_w = $urandom_range(0, 40);
        cf_w = {16'($urandom()), 16'($urandom_range(0, 12))};
        pw_w = $urandom_range(0, 24);
        ps_w = $urandom_range(0, 40);
        cs_w = {16'($urandom()), 16'($urandom_range(0, 12))};
        amp_w = $urandom();
      end else if (style == 2) begin
        st_w  = $urandom();
        pf_w  = $urandom();
        cf_w  = $urandom();
        pw_w  = $urandom();
        ps_w  = $urandom();
        cs_w  = $urandom();
        amp_w = $urandom();
      end else begin
        st_w  = corner_value();
        pf_w  = corner_value();
        cf_w  = corner_value();
        pw_w  = corner_value();
        ps_w  = corner_value();
        cs_w  = corner_value();
        amp_w = corner_value();
      end
      write_reg(REG_START_TIME, st_w);
      write_reg(REG_PERIOD_FIRST, pf_w);
      write_reg(REG_PULSE_WIDTH, pw_w);
      write_reg(REG_AMPLITUDE, amp_w);
      write_reg(REG_COUNT_FIRST, cf_w);
      write_reg(REG_PERIOD_SECOND, ps_w);
      write_reg(REG_COUNT_SECOND, cs_w);
      cfg_we <= 1'b0;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_time(pick_tick(st_w, pf_w, cf_w[COUNT_BITS-1:0], ps_w, cs_w[COUNT_BITS-1:0]));
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ s1_s2_pulse_train_stimulus.f @@
rtl/pts_pkg.sv
rtl/pts_cfg.sv
rtl/pts_cell.sv
rtl/s1_s2_pulse_train_stimulus.sv
tb/pts_checker.sv
tb/tb.sv
